### rtl/core/assert_macros.svh
// assertion macros used by the top level of the countdown clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must be followed by a consequence in the next cycle
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/scc_pkg.sv
// types, codes and reset values of the countdown clock
package scc_pkg;

	localparam int TICKS_PER_SECOND_DEF = 1000;
	localparam int MAX_SECONDS_DEF      = 99;

	localparam int SEC_W  = 7;
	localparam int WIN_W  = 16;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_RESET = 3'd3,
		CMD_SYNC  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_STOP = 2'd2
	} mode_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_DUP_WINDOW = 2'd0,
		CFG_SYNC_TOL   = 2'd1,
		CFG_WARN_LEVEL = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [SEC_W-1:0] seconds_value;
	} in_t;

	typedef struct packed {
		logic [SEC_W-1:0] shown_seconds;
		logic [1:0]       clock_state;
		logic             has_signal;
		logic             expire_alert;
		logic             warn_alert;
		logic             display_update;
	} out_t;

	typedef struct packed {
		logic [WIN_W-1:0] dup_window;
		logic [SEC_W-1:0] sync_tol;
		logic [SEC_W-1:0] warn_level;
	} cfg_t;

	// everything but the sub-second counter, whose width follows the tick rate
	typedef struct packed {
		mode_t            mode;
		logic [SEC_W-1:0] start_s;
		logic [SEC_W-1:0] elap_s;
		logic [SEC_W-1:0] held_s;
		logic             expired;
		logic [SEC_W-1:0] last_warned;
		logic             seen;
		logic [7:0]       last_shown;
		logic             last_signal;
	} state_t;

	localparam logic [SEC_W-1:0] SEC_SAT   = 7'd127;
	localparam logic [SEC_W-1:0] WARN_NONE = 7'd99;
	localparam logic [7:0]       SHOWN_NONE = 8'd255;
	localparam logic [SEC_W-1:0] START_RST = 7'd30;

	localparam cfg_t CFG_RESET = '{
		dup_window: 16'd1500,
		sync_tol:   7'd1,
		warn_level: 7'd5
	};

	localparam state_t STATE_RESET = '{
		mode:        MODE_IDLE,
		start_s:     START_RST,
		elap_s:      7'd0,
		held_s:      START_RST,
		expired:     1'b0,
		last_warned: WARN_NONE,
		seen:        1'b0,
		last_shown:  SHOWN_NONE,
		last_signal: 1'b0
	};

endpackage

### rtl/core/scc_step.sv
// next-state and result logic for one beat of the countdown clock
module scc_step #(
	parameter int TICKS_PER_SECOND = scc_pkg::TICKS_PER_SECOND_DEF,
	parameter int MAX_SECONDS      = scc_pkg::MAX_SECONDS_DEF,
	parameter int MS_W             = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1
) (
	input  scc_pkg::in_t    item,
	input  scc_pkg::cfg_t   cfg,
	input  scc_pkg::state_t st,
	input  logic [MS_W-1:0] ms,
	output scc_pkg::state_t nxt,
	output logic [MS_W-1:0] nxt_ms,
	output scc_pkg::out_t   res
);

	localparam int SINCE_W = $clog2(128 * TICKS_PER_SECOND);
	localparam int CMP_W   = (SINCE_W > scc_pkg::WIN_W) ? SINCE_W : scc_pkg::WIN_W;
	localparam logic [SINCE_W-1:0]       TICKS_K = SINCE_W'(TICKS_PER_SECOND);
	localparam logic [MS_W-1:0]          MS_LAST = MS_W'(TICKS_PER_SECOND - 1);
	localparam logic [scc_pkg::SEC_W-1:0] MAX_K  = scc_pkg::SEC_W'(MAX_SECONDS);

	logic [scc_pkg::SEC_W-1:0] sec;
	logic [scc_pkg::SEC_W-1:0] live;
	logic [scc_pkg::SEC_W-1:0] diff;
	logic [scc_pkg::SEC_W-1:0] cnt;
	logic [scc_pkg::SEC_W-1:0] shown;
	logic [SINCE_W-1:0]        since;
	logic                      dup;

	always_comb begin
		sec = (item.seconds_value > MAX_K) ? MAX_K : item.seconds_value;
		since = SINCE_W'(st.elap_s) * TICKS_K + SINCE_W'(ms);
		dup = (st.mode == scc_pkg::MODE_RUN) && (sec == st.start_s)
			&& (CMP_W'(since) < CMP_W'(cfg.dup_window));

		if (st.mode != scc_pkg::MODE_RUN) begin
			live = st.held_s;
		end else if (st.elap_s >= st.start_s) begin
			live = '0;
		end else begin
			live = st.start_s - st.elap_s;
		end
		diff = (live > sec) ? (live - sec) : (sec - live);

		nxt = st;
		nxt_ms = ms;
		res = '0;

		if (item.cmd != scc_pkg::CMD_TICK) begin
			nxt.seen = 1'b1;
		end

		unique case (item.cmd)
			scc_pkg::CMD_TICK: begin
				if (st.mode == scc_pkg::MODE_RUN) begin
					if (ms == MS_LAST) begin
						nxt_ms = '0;
						if (st.elap_s < scc_pkg::SEC_SAT) begin
							nxt.elap_s = st.elap_s + 1'b1;
						end
					end else begin
						nxt_ms = ms + 1'b1;
					end
				end
			end
			scc_pkg::CMD_START: begin
				if (!dup) begin
					nxt.start_s = sec;
					nxt.elap_s = '0;
					nxt_ms = '0;
					nxt.mode = scc_pkg::MODE_RUN;
					nxt.held_s = sec;
					nxt.expired = 1'b0;
					nxt.last_warned = (sec < scc_pkg::SEC_SAT) ? sec + 1'b1 : scc_pkg::SEC_SAT;
				end
			end
			scc_pkg::CMD_STOP: begin
				nxt.held_s = sec;
				nxt.mode = scc_pkg::MODE_STOP;
			end
			scc_pkg::CMD_RESET: begin
				nxt.held_s = sec;
				nxt.start_s = sec;
				nxt.mode = scc_pkg::MODE_STOP;
				nxt.expired = 1'b0;
				nxt.last_warned = scc_pkg::WARN_NONE;
			end
			scc_pkg::CMD_SYNC: begin
				if (st.mode == scc_pkg::MODE_RUN && diff > cfg.sync_tol) begin
					if (sec > st.start_s) begin
						nxt.start_s = sec;
						nxt.elap_s = '0;
					end else begin
						nxt.elap_s = st.start_s - sec;
					end
					nxt_ms = '0;
				end
			end
			default: begin
				// unused codes only mark a packet as seen
			end
		endcase

		// count check after the item
		if (nxt.mode != scc_pkg::MODE_RUN) begin
			cnt = nxt.held_s;
		end else if (nxt.elap_s >= nxt.start_s) begin
			cnt = '0;
		end else begin
			cnt = nxt.start_s - nxt.elap_s;
		end

		if (nxt.mode == scc_pkg::MODE_RUN && cnt == '0) begin
			nxt.mode = scc_pkg::MODE_STOP;
			nxt.held_s = '0;
			if (!nxt.expired) begin
				nxt.expired = 1'b1;
				res.expire_alert = 1'b1;
			end
		end

		if (nxt.mode == scc_pkg::MODE_RUN && cnt <= cfg.warn_level && cnt != '0
				&& cnt != nxt.last_warned) begin
			nxt.last_warned = cnt;
			res.warn_alert = 1'b1;
		end

		shown = (nxt.mode == scc_pkg::MODE_RUN) ? cnt : nxt.held_s;
		if ({1'b0, shown} != nxt.last_shown || nxt.seen != nxt.last_signal) begin
			nxt.last_shown = {1'b0, shown};
			nxt.last_signal = nxt.seen;
			res.display_update = 1'b1;
		end

		res.shown_seconds = shown;
		res.clock_state = nxt.mode;
		res.has_signal = nxt.seen;
	end

endmodule

### rtl/core/synced_countdown_clock_unit.sv
// top level of the remotely commanded countdown clock
//
//  channel  | handshake                   | beat
//  ---------+-----------------------------+--------------------------------
//  item     | item_valid / item_stall     | scc_pkg::in_t  (cmd, seconds)
//  result   | result_valid / result_stall | scc_pkg::out_t (one per item)
//  config   | cfg_we                      | cfg_index, cfg_data
//
// one item per cycle sustained while result_stall is low; an accepted beat is
// processed from the input register and sits in the result register once free
// reset: state and config take their reset values at once, no clearing pass
// a stalled result holds in the result register; the input register keeps
// accepting until it is full, then item_stall follows result_stall
`include "assert_macros.svh"

module synced_countdown_clock_unit #(
	parameter int TICKS_PER_SECOND = scc_pkg::TICKS_PER_SECOND_DEF,
	parameter int MAX_SECONDS      = scc_pkg::MAX_SECONDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  scc_pkg::in_t                item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output scc_pkg::out_t               result,
	input  logic                        cfg_we,
	input  logic [scc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [scc_pkg::CFG_W-1:0]  cfg_data
);

	localparam int MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
	localparam logic [MS_W-1:0] MS_LAST = MS_W'(TICKS_PER_SECOND - 1);

	// input register
	scc_pkg::in_t    item_s1;
	logic            valid_s1;

	// clock state, sub-second counter and config
	scc_pkg::state_t state_q;
	logic [MS_W-1:0] ms_q;
	scc_pkg::cfg_t   cfg_q;

	// step logic outputs
	scc_pkg::state_t state_nxt;
	logic [MS_W-1:0] ms_nxt;
	scc_pkg::out_t   res_nxt;

	// result register
	scc_pkg::out_t   result_q;
	logic            result_valid_q;

	logic out_free;
	logic advance;
	logic take;

	// result beat views used by the checks
	logic res_expire;
	logic res_run;
	logic res_stop_zero;

	// result register can load when empty or being taken this cycle
	assign out_free = !result_valid_q || !result_stall;
	// the beat in the input register is processed and its state committed
	assign advance = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign take = item_valid && !item_stall;

	scc_step #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.MAX_SECONDS(MAX_SECONDS),
		.MS_W(MS_W)
	) u_step (
		.item(item_s1),
		.cfg(cfg_q),
		.st(state_q),
		.ms(ms_q),
		.nxt(state_nxt),
		.nxt_ms(ms_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// state commits only when the result can be stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::STATE_RESET;
			ms_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			ms_q <= ms_nxt;
		end
	end

	// config writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= scc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scc_pkg::CFG_DUP_WINDOW: cfg_q.dup_window <= cfg_data;
				scc_pkg::CFG_SYNC_TOL:   cfg_q.sync_tol <= cfg_data[scc_pkg::SEC_W-1:0];
				scc_pkg::CFG_WARN_LEVEL: cfg_q.warn_level <= cfg_data[scc_pkg::SEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	assign res_expire = result_valid && result.expire_alert;
	assign res_run = result_valid && result.clock_state == scc_pkg::MODE_RUN;
	assign res_stop_zero = result.clock_state == scc_pkg::MODE_STOP
		&& result.shown_seconds == '0;

	// an expire beat always reports a stopped clock at zero
	`SCC_ASSERT(a_expire_at_zero, res_expire |-> res_stop_zero, "expire without stop at zero")
	// a running clock never shows zero
	`SCC_ASSERT(a_run_nonzero, res_run |-> result.shown_seconds != '0, "running clock shows zero")
	// expire and warn never fire on the same beat
	`SCC_ASSERT(a_alert_excl, res_expire |-> !result.warn_alert, "expire and warn together")
	// sub-second counter stays below one second
	`SCC_ASSERT(a_ms_range, ms_q <= MS_LAST, "sub-second counter out of range")
	// a processed beat shows up as a result next cycle
	`SCC_ASSERT_NEXT(a_advance_result, advance, result_valid, "processed beat lost")

endmodule

### test/tb_synced_countdown_clock_unit.sv
// testbench of the countdown clock: directed table, random countdowns, predicted results
module tb_synced_countdown_clock_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// command codes the block does not decode, still counted as packets
	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

	localparam logic [scc_pkg::SEC_W-1:0] SEC_TOP = scc_pkg::SEC_W'(scc_pkg::MAX_SECONDS_DEF);
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_LIMIT = 10;

	// one row of the directed table; want is only used where typed is set
	typedef struct packed {
		scc_pkg::in_t  beat;
		logic          typed;
		scc_pkg::out_t want;
	} row_t;

	localparam scc_pkg::out_t NO_WANT = '0;
	localparam int PLAN_ROWS = 23;

	// reset config: window 1500, tolerance 1, warn level 5
	localparam row_t PLAN [PLAN_ROWS] = '{
		// first beat after reset: idle, held 30, first report always updates
		'{'{scc_pkg::CMD_TICK, 7'd0}, 1'b1,
			'{7'd30, scc_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b1}},
		// undecoded code only raises the signal flag
		'{'{CMD_SPARE_LO, 7'd127}, 1'b1,
			'{7'd30, scc_pkg::MODE_IDLE, 1'b1, 1'b0, 1'b0, 1'b1}},
		// seconds above the maximum saturate
		'{'{scc_pkg::CMD_START, 7'd127}, 1'b1,
			'{7'd99, scc_pkg::MODE_RUN, 1'b1, 1'b0, 1'b0, 1'b1}},
		// same start inside the duplicate window is dropped
		'{'{scc_pkg::CMD_START, 7'd99}, 1'b1,
			'{7'd99, scc_pkg::MODE_RUN, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{scc_pkg::CMD_SYNC, 7'd127}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_SYNC, 7'd50}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_SYNC, 7'd51}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_TICK, 7'd77}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_STOP, 7'd10}, 1'b0, NO_WANT},
		// ticks do nothing while stopped
		'{'{scc_pkg::CMD_TICK, 7'd0}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_RESET, 7'd0}, 1'b1,
			'{7'd0, scc_pkg::MODE_STOP, 1'b1, 1'b0, 1'b0, 1'b1}},
		// start at zero expires on the spot
		'{'{scc_pkg::CMD_START, 7'd0}, 1'b1,
			'{7'd0, scc_pkg::MODE_STOP, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{'{scc_pkg::CMD_START, 7'd0}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_START, 7'd3}, 1'b0, NO_WANT},
		// sync above the start value restarts from it
		'{'{scc_pkg::CMD_SYNC, 7'd127}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_SYNC, 7'd4}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_SYNC, 7'd0}, 1'b0, NO_WANT},
		'{'{CMD_SPARE_MID, 7'd85}, 1'b0, NO_WANT},
		'{'{CMD_SPARE_HI, 7'd42}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_START, 7'd2}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_SYNC, 7'd2}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_STOP, 7'd127}, 1'b0, NO_WANT},
		'{'{scc_pkg::CMD_RESET, 7'd99}, 1'b0, NO_WANT}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	scc_pkg::in_t               item = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	scc_pkg::out_t              result;
	logic                       cfg_we = 1'b0;
	logic [scc_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [scc_pkg::CFG_W-1:0]  cfg_data = '0;

	// predicted state of the clock and its registers
	scc_pkg::mode_t            ck_mode = scc_pkg::MODE_IDLE;
	logic [scc_pkg::SEC_W-1:0] ck_start = scc_pkg::START_RST;
	logic [scc_pkg::SEC_W-1:0] ck_elap = '0;
	logic [9:0]                ck_ms = '0;
	logic [scc_pkg::SEC_W-1:0] ck_held = scc_pkg::START_RST;
	logic                      ck_expired = 1'b0;
	logic [scc_pkg::SEC_W-1:0] ck_last_warned = scc_pkg::WARN_NONE;
	logic                      ck_seen = 1'b0;
	logic [7:0]                ck_last_shown = scc_pkg::SHOWN_NONE;
	logic                      ck_last_signal = 1'b0;
	logic [scc_pkg::WIN_W-1:0] ck_window = scc_pkg::CFG_RESET.dup_window;
	logic [scc_pkg::SEC_W-1:0] ck_tol = scc_pkg::CFG_RESET.sync_tol;
	logic [scc_pkg::SEC_W-1:0] ck_warn = scc_pkg::CFG_RESET.warn_level;

	scc_pkg::out_t display_queue [$];
	int   mismatches = 0;
	int   phase_beats = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;

	synced_countdown_clock_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	// seconds on the display right now, as the predictor sees it
	function automatic logic [scc_pkg::SEC_W-1:0] count_now();
		if (ck_mode != scc_pkg::MODE_RUN) return ck_held;
		if (ck_elap >= ck_start) return '0;
		return ck_start - ck_elap;
	endfunction

	// advance the predicted clock by one beat and return the report it gives
	function automatic scc_pkg::out_t clock_model_step(scc_pkg::in_t b);
		logic [scc_pkg::SEC_W-1:0] secs;
		logic [scc_pkg::SEC_W-1:0] cnt;
		logic [scc_pkg::SEC_W-1:0] here;
		logic [scc_pkg::SEC_W-1:0] shown;
		int                        diff;
		int                        since;
		scc_pkg::out_t             o;
		o = '0;
		secs = (b.seconds_value > SEC_TOP) ? SEC_TOP : b.seconds_value;
		if (b.cmd == scc_pkg::CMD_TICK) begin
			// time only moves while running
			if (ck_mode == scc_pkg::MODE_RUN) begin
				ck_ms = ck_ms + 1'b1;
				if (ck_ms >= scc_pkg::TICKS_PER_SECOND_DEF) begin
					ck_ms = '0;
					if (ck_elap < scc_pkg::SEC_SAT) ck_elap = ck_elap + 1'b1;
				end
			end
		end else begin
			ck_seen = 1'b1;
			case (b.cmd)
				scc_pkg::CMD_START: begin
					since = int'(ck_elap) * scc_pkg::TICKS_PER_SECOND_DEF + int'(ck_ms);
					if (!(ck_mode == scc_pkg::MODE_RUN && secs == ck_start
							&& since < int'(ck_window))) begin
						ck_start = secs;
						ck_elap = '0;
						ck_ms = '0;
						ck_mode = scc_pkg::MODE_RUN;
						ck_held = secs;
						ck_expired = 1'b0;
						ck_last_warned = secs + 1'b1;
					end
				end
				scc_pkg::CMD_STOP: begin
					ck_held = secs;
					ck_mode = scc_pkg::MODE_STOP;
				end
				scc_pkg::CMD_RESET: begin
					ck_held = secs;
					ck_start = secs;
					ck_mode = scc_pkg::MODE_STOP;
					ck_expired = 1'b0;
					ck_last_warned = scc_pkg::WARN_NONE;
				end
				scc_pkg::CMD_SYNC: begin
					if (ck_mode == scc_pkg::MODE_RUN) begin
						here = count_now();
						diff = (here > secs) ? int'(here - secs) : int'(secs - here);
						if (diff > int'(ck_tol)) begin
							if (secs > ck_start) begin
								ck_start = secs;
								ck_elap = '0;
							end else begin
								ck_elap = ck_start - secs;
							end
							ck_ms = '0;
						end
					end
				end
				default: ;
			endcase
		end
		cnt = count_now();
		if (ck_mode == scc_pkg::MODE_RUN && cnt == '0) begin
			ck_mode = scc_pkg::MODE_STOP;
			ck_held = '0;
			if (!ck_expired) begin
				ck_expired = 1'b1;
				o.expire_alert = 1'b1;
			end
		end
		if (ck_mode == scc_pkg::MODE_RUN && cnt <= ck_warn && cnt != '0
				&& cnt != ck_last_warned) begin
			ck_last_warned = cnt;
			o.warn_alert = 1'b1;
		end
		shown = (ck_mode == scc_pkg::MODE_RUN) ? cnt : ck_held;
		if ({1'b0, shown} != ck_last_shown || ck_seen != ck_last_signal) begin
			ck_last_shown = {1'b0, shown};
			ck_last_signal = ck_seen;
			o.display_update = 1'b1;
		end
		o.shown_seconds = shown;
		o.clock_state = ck_mode;
		o.has_signal = ck_seen;
		return o;
	endfunction

	// offer one beat, with random idle cycles ahead of it, and wait for the accept
	task automatic send_beat(scc_pkg::in_t b);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic issue(logic [2:0] code, int secs);
		scc_pkg::in_t b;
		b.cmd = code;
		b.seconds_value = secs[scc_pkg::SEC_W-1:0];
		send_beat(b);
		display_queue.push_back(clock_model_step(b));
		phase_beats++;
	endtask

	// ticks carry random seconds, which the block must ignore
	task automatic tick_run(int n);
		repeat (n) issue(scc_pkg::CMD_TICK, $urandom_range(127));
	endtask

	// stop offering, let every report come back, then cover the pipeline
	task automatic settle();
		item_valid <= 1'b0;
		while (display_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all three registers back to back; the block is idle here
	task automatic set_registers(logic [scc_pkg::WIN_W-1:0] win,
			logic [scc_pkg::SEC_W-1:0] tol, logic [scc_pkg::SEC_W-1:0] lvl);
		cfg_we <= 1'b1;
		cfg_index <= scc_pkg::CFG_DUP_WINDOW;
		cfg_data <= win;
		@(posedge clk);
		ck_window = win;
		cfg_index <= scc_pkg::CFG_SYNC_TOL;
		cfg_data <= scc_pkg::CFG_W'(tol);
		@(posedge clk);
		ck_tol = tol;
		cfg_index <= scc_pkg::CFG_WARN_LEVEL;
		cfg_data <= scc_pkg::CFG_W'(lvl);
		@(posedge clk);
		ck_warn = lvl;
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed countdowns with random content, the rest noise
	task automatic play_random(int quota);
		int pick;
		int steps;
		int base;
		int aim;
		while (phase_beats < quota) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// small start values so expiry and warnings come often
				base = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(8);
				issue(scc_pkg::CMD_START, base);
				steps = $urandom_range(6, 1);
				repeat (steps) begin
					case ($urandom_range(5))
						0, 1: tick_run($urandom_range(40, 1));
						2: begin
							// sync near the live count, either side of the tolerance
							aim = int'(count_now()) + int'($urandom_range(8)) - 4;
							if (aim < 0) aim = 0;
							issue(scc_pkg::CMD_SYNC, aim);
						end
						3: issue(scc_pkg::CMD_START, ($urandom_range(2) != 0) ? int'(ck_start)
							: int'($urandom_range(127)));
						4: issue(scc_pkg::CMD_SYNC, $urandom_range(127));
						default: issue(($urandom_range(1) != 0) ? scc_pkg::CMD_STOP
							: scc_pkg::CMD_RESET, $urandom_range(127));
					endcase
				end
			end else if (pick < 80) begin
				tick_run($urandom_range(40, 1));
			end else begin
				issue(3'($urandom_range(7)), $urandom_range(127));
			end
		end
	endtask

	// receiver side: check each accepted beat and pick the next stall
	always @(posedge clk) begin : result_check
		scc_pkg::out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (display_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"unexpected result beat: ",
						"shown=%0d state=%0d sig=%b exp=%b warn=%b upd=%b"},
						result.shown_seconds, result.clock_state, result.has_signal,
						result.expire_alert, result.warn_alert, result.display_update);
			end else begin
				want = display_queue.pop_front();
				if (result.shown_seconds !== want.shown_seconds
						|| result.clock_state !== want.clock_state
						|| result.has_signal !== want.has_signal
						|| result.expire_alert !== want.expire_alert
						|| result.warn_alert !== want.warn_alert
						|| result.display_update !== want.display_update) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"mismatch at %0t: expected ",
							"shown=%0d state=%0d sig=%b exp=%b warn=%b upd=%b, got ",
							"shown=%0d state=%0d sig=%b exp=%b warn=%b upd=%b"},
							$realtime, want.shown_seconds, want.clock_state, want.has_signal,
							want.expire_alert, want.warn_alert, want.display_update,
							result.shown_seconds, result.clock_state, result.has_signal,
							result.expire_alert, result.warn_alert, result.display_update);
				end
			end
		end
		// a long hold-off overrides the random stall
		result_stall <= (hold_go && !hold_done) || ($urandom_range(99) < stall_pct);
	end

	// long receiver hold-off, counted here while the sender keeps offering
	initial begin : receiver_hold
		wait (hold_go);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_done <= 1'b1;
	end

	initial begin : stimulus
		int guard;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset config, no idling
		for (int r = 0; r < PLAN_ROWS; r++) begin
			send_beat(PLAN[r].beat);
			if (PLAN[r].typed) begin
				void'(clock_model_step(PLAN[r].beat));
				display_queue.push_back(PLAN[r].want);
			end else begin
				display_queue.push_back(clock_model_step(PLAN[r].beat));
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			phase_beats = 0;
			case (ph)
				0: begin
					// reset config, no idling; one countdown across a whole second
					idle_pct = 0;
					stall_pct = 0;
					issue(scc_pkg::CMD_START, 4);
					tick_run(100);
					// correcting sync clears the sub-second phase
					issue(scc_pkg::CMD_SYNC, 2);
					tick_run(1000);
					issue(scc_pkg::CMD_RESET, 30);
					phase_beats = 0;
					play_random(40);
				end
				1: begin
					// low extremes, sender idles often
					set_registers('0, '0, '0);
					idle_pct = 58;
					stall_pct = 0;
					play_random(80);
				end
				2: begin
					// high extremes, receiver stalls often
					set_registers('1, SEC_TOP, SEC_TOP);
					idle_pct = 0;
					stall_pct = 58;
					play_random(80);
				end
				default: begin
					// short windows so repeated starts land on both sides
					set_registers(scc_pkg::WIN_W'($urandom_range(40, 1)),
						scc_pkg::SEC_W'($urandom_range(3)),
						scc_pkg::SEC_W'($urandom_range(10, 1)));
					idle_pct = 12;
					stall_pct = 12;
					// fill the block against a held receiver
					hold_go <= 1'b1;
					play_random(80);
				end
			endcase
		end

		item_valid <= 1'b0;
		guard = 0;
		while (display_queue.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && display_queue.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin : run_limit
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/scc_step.sv
rtl/core/synced_countdown_clock_unit.sv
test/tb_synced_countdown_clock_unit.sv
